>>> rtl/bsp_pkg.sv
// Shared constants and codes for the bilinear scaler with palette.
package bsp_pkg;
	localparam int SRC_SIZE = 512;
	localparam int SRC_AW = $clog2(SRC_SIZE);
	localparam int BANK_DEPTH = (SRC_SIZE / 2) * (SRC_SIZE / 2);
	localparam int BANK_AW = $clog2(BANK_DEPTH);
	localparam int RATIO_W = 28;
	localparam int DEST_W = 12;
	localparam int FRAC_W = 8;
	localparam int WEIGHT_W = 2 * FRAC_W + 1;
	localparam int POS_W = DEST_W + 1 + RATIO_W + 1;
	localparam int PAL_DEPTH = 256;
	localparam int COLOR_W = 24;
	localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(65536);
	localparam logic [SRC_AW-1:0] BASE_MAX = SRC_AW'(SRC_SIZE - 2);

	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_PALETTE = 2'd1;
	localparam logic [1:0] CMD_RENDER = 2'd2;
	localparam logic [1:0] CMD_NOP = 2'd3;

	localparam logic REG_WIDTH_RATIO = 1'b0;
	localparam logic REG_HEIGHT_RATIO = 1'b1;

	typedef struct packed {
		logic [SRC_AW-1:0] base;
		logic [FRAC_W-1:0] frac;
	} axis_pos_t;
endpackage

>>> rtl/bsp_ram.sv
// Generic single-port RAM with registered read and read enable.
module bsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and register the old data at the address (read before write); both hold while en is low.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end
endmodule

>>> rtl/bsp_axis.sv
// One axis of the source position: registered multiply, then clamp and fraction.
module bsp_axis (
	input  logic                         clk,
	input  logic                         en,
	input  logic [bsp_pkg::DEST_W-1:0]   dest,
	input  logic [bsp_pkg::RATIO_W-1:0]  ratio,
	output bsp_pkg::axis_pos_t           pos
);
	import bsp_pkg::*;

	logic [POS_W-1:0] u_s1;
	logic [POS_W-1:0] prod;
	logic [POS_W-18:0] whole;

	// Position in Q17, offset by one source sample: (2d+1)*ratio + 0.5.
	assign prod = POS_W'({dest, 1'b1}) * POS_W'(ratio) + POS_W'(65536);

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= prod;
		end
	end

	// Floor plus one, clamped to the last full neighbor pair.
	assign whole = u_s1[POS_W-1:17];
	assign pos.base = (whole > ($bits(whole))'(BASE_MAX)) ? BASE_MAX : whole[SRC_AW-1:0];
	assign pos.frac = u_s1[16:9];
endmodule

>>> rtl/bsp_blend.sv
// Bilinear blend: weights registered in one stage, weighted sum in the next.
module bsp_blend (
	input  logic                        clk,
	input  logic                        en,
	input  logic [bsp_pkg::FRAC_W-1:0]  fx,
	input  logic [bsp_pkg::FRAC_W-1:0]  fy,
	input  logic [7:0]                  s00,
	input  logic [7:0]                  s01,
	input  logic [7:0]                  s10,
	input  logic [7:0]                  s11,
	output logic [7:0]                  level
);
	import bsp_pkg::*;

	logic [FRAC_W:0] gx, gy, fxe, fye;
	logic [WEIGHT_W-1:0] w00_s3, w01_s3, w10_s3, w11_s3;
	logic [7:0] s00_s3, s01_s3, s10_s3, s11_s3;
	logic [WEIGHT_W+7:0] sum;

	assign fxe = {1'b0, fx};
	assign fye = {1'b0, fy};
	assign gx = (FRAC_W+1)'(256) - fxe;
	assign gy = (FRAC_W+1)'(256) - fye;

	// Register the four corner weights with their samples.
	always_ff @(posedge clk) begin
		if (en) begin
			w00_s3 <= WEIGHT_W'(gx * gy);
			w01_s3 <= WEIGHT_W'(gx * fye);
			w10_s3 <= WEIGHT_W'(fxe * gy);
			w11_s3 <= WEIGHT_W'(fxe * fye);
			s00_s3 <= s00;
			s01_s3 <= s01;
			s10_s3 <= s10;
			s11_s3 <= s11;
		end
	end

	// Weighted sum, truncated to the integer amplitude.
	assign sum = (WEIGHT_W+8)'(w00_s3 * s00_s3) + (WEIGHT_W+8)'(w01_s3 * s01_s3)
		+ (WEIGHT_W+8)'(w10_s3 * s10_s3) + (WEIGHT_W+8)'(w11_s3 * s11_s3);
	assign level = sum[23:16];
endmodule

>>> rtl/bilinear_scaler_palette.sv
// Top level of the bilinear scaler with palette lookup.
// Input items arrive on the s_ stream; s_tuser carries the command (sample
// write, palette write or pixel render), s_tdata the remaining fields.
// Each render yields one transfer on the m_ stream with the three palette
// bytes; writes yield nothing. The ratio registers are written through the
// cfg_ channel, always ready; the user must write them only while the block
// is idle; the block does not enforce this. The pipeline takes one item per
// cycle unless stalled. A render passes the stages axis multiply, source
// bank read, weight stage and palette read. The source image sits in four
// banks split by the parity of both coordinates, so the four neighbors of a
// pixel come from four different banks in the same cycle.
// Reset clears the valid bits and sets both ratios to 1.0; the source image
// and palette hold whatever they held until written.
// When the receiver stalls the whole pipeline holds, s_tready drops, and
// nothing is lost or repeated.
module bilinear_scaler_palette (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: src_first, src_second, sample, palette_index, color, dest_x, dest_y, zero pad
	input  logic [87:0] s_tdata,
	// s_tuser: command
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: byte0, byte1, byte2
	output logic [23:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [27:0] cfg_data
);
	import bsp_pkg::*;

	logic en;
	logic [RATIO_W-1:0] width_ratio_q, height_ratio_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic [1:0] cmd_s1, cmd_s2, cmd_s3;
	logic [SRC_AW-1:0] first_s1, second_s1;
	logic [7:0] sample_s1;
	logic [7:0] pidx_s1, pidx_s2, pidx_s3;
	logic [COLOR_W-1:0] color_s1, color_s2, color_s3;
	logic [FRAC_W-1:0] fx_s2, fy_s2;
	logic px_s2, py_s2;

	axis_pos_t xpos, ypos;
	logic [SRC_AW-1:0] ax_even, ax_odd, ay_even, ay_odd;
	logic [7:0] bank_rd [4];
	logic [7:0] s00, s01, s10, s11, level;
	logic pal_we;
	logic [7:0] pal_addr;
	logic [COLOR_W-1:0] pal_rd;

	assign en = !vld_s4 || m_tready;
	assign s_tready = en;
	assign cfg_ready = 1'b1;

	// Ratio registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_ratio_q <= RATIO_RESET;
			height_ratio_q <= RATIO_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH_RATIO: width_ratio_q <= cfg_data;
				REG_HEIGHT_RATIO: height_ratio_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits travel with the items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3 && (cmd_s3 == CMD_RENDER);
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= s_tuser;
			first_s1 <= s_tdata[8:0];
			second_s1 <= s_tdata[17:9];
			sample_s1 <= s_tdata[25:18];
			pidx_s1 <= s_tdata[33:26];
			color_s1 <= s_tdata[57:34];
			cmd_s2 <= cmd_s1;
			pidx_s2 <= pidx_s1;
			color_s2 <= color_s1;
			fx_s2 <= xpos.frac;
			fy_s2 <= ypos.frac;
			px_s2 <= xpos.base[0];
			py_s2 <= ypos.base[0];
			cmd_s3 <= cmd_s2;
			pidx_s3 <= pidx_s2;
			color_s3 <= color_s2;
		end
	end

	bsp_axis u_axis_x (
		.clk(clk), .en(en), .dest(s_tdata[69:58]), .ratio(width_ratio_q), .pos(xpos)
	);
	bsp_axis u_axis_y (
		.clk(clk), .en(en), .dest(s_tdata[81:70]), .ratio(height_ratio_q), .pos(ypos)
	);

	// Row of each parity among the neighbor pair.
	assign ax_even = (xpos.base + SRC_AW'(1)) >> 1;
	assign ax_odd = xpos.base >> 1;
	assign ay_even = (ypos.base + SRC_AW'(1)) >> 1;
	assign ay_odd = ypos.base >> 1;

	// Four source banks indexed by {first parity, second parity}.
	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic we;
		logic [BANK_AW-1:0] addr;
		logic [SRC_AW-2:0] ra, rb;
		assign ra = (b / 2 == 1) ? ax_odd[SRC_AW-2:0] : ax_even[SRC_AW-2:0];
		assign rb = (b % 2 == 1) ? ay_odd[SRC_AW-2:0] : ay_even[SRC_AW-2:0];
		assign we = en && vld_s1 && (cmd_s1 == CMD_SAMPLE)
			&& ({first_s1[0], second_s1[0]} == 2'(b));
		assign addr = (cmd_s1 == CMD_SAMPLE) ? {first_s1[SRC_AW-1:1], second_s1[SRC_AW-1:1]}
			: {ra, rb};
		bsp_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ram (
			.clk(clk), .en(en), .we(we), .addr(addr), .wdata(sample_s1), .rdata(bank_rd[b])
		);
	end

	// Route bank data to the corners by the parity of the lower neighbor.
	assign s00 = bank_rd[{px_s2, py_s2}];
	assign s01 = bank_rd[{px_s2, !py_s2}];
	assign s10 = bank_rd[{!px_s2, py_s2}];
	assign s11 = bank_rd[{!px_s2, !py_s2}];

	bsp_blend u_blend (
		.clk(clk), .en(en), .fx(fx_s2), .fy(fy_s2),
		.s00(s00), .s01(s01), .s10(s10), .s11(s11), .level(level)
	);

	// Palette: written and read at the same stage, so item order is kept.
	assign pal_we = en && vld_s3 && (cmd_s3 == CMD_PALETTE);
	assign pal_addr = (cmd_s3 == CMD_PALETTE) ? pidx_s3 : level;

	bsp_ram #(.WIDTH(COLOR_W), .DEPTH(PAL_DEPTH)) u_palette (
		.clk(clk), .en(en), .we(pal_we), .addr(pal_addr), .wdata(color_s3), .rdata(pal_rd)
	);

	assign m_tvalid = vld_s4;
	assign m_tdata = pal_rd;

	// Input is refused only while a result is stalled at the output.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready)) else $error("ready dropped without stall");
	// A stalled pipeline keeps its inner valid bits.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(vld_s1) && $stable(vld_s2) && $stable(vld_s3)))
		else $error("pipeline moved during stall");
	// Only a render reaching the palette stage raises the output.
	a_render: assert property (@(posedge clk) disable iff (!arst_n)
		(en && !(vld_s3 && cmd_s3 == CMD_RENDER)) |=> !m_tvalid)
		else $error("result without render");
endmodule

>>> test/bilinear_scaler_palette_checker.sv
// Checker that predicts and compares pixel results of the bilinear scaler with palette.
`timescale 1ns / 100ps

module bilinear_scaler_palette_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [87:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [27:0] cfg_data,
	output int          pending,
	output int          errors
);
	import bsp_pkg::*;

	logic [7:0] image_mem [0:SRC_SIZE*SRC_SIZE-1];
	logic [COLOR_W-1:0] colors [0:PAL_DEPTH-1];
	logic [RATIO_W-1:0] x_ratio, y_ratio;
	logic [COLOR_W-1:0] pixel_queue [$];

	// Base index (floor plus one, clamped) and Q8 fraction of one axis.
	function automatic void locate(input logic [11:0] d, input logic [27:0] r,
			output logic [8:0] base, output logic [7:0] frac);
		logic [47:0] u;
		u = (48'(d) * 2 + 1) * 48'(r) + 48'd65536;
		frac = u[16:9];
		base = ((u >> 17) > 48'(SRC_SIZE - 2)) ? 9'(SRC_SIZE - 2) : u[25:17];
	endfunction

	function automatic logic [23:0] shade(input logic [11:0] dx, input logic [11:0] dy);
		logic [8:0] bx, by;
		logic [7:0] fx, fy;
		logic [31:0] gx, gy, sum;
		locate(dx, x_ratio, bx, fx);
		locate(dy, y_ratio, by, fy);
		gx = 256 - fx;
		gy = 256 - fy;
		sum = gx * gy * image_mem[{bx, by}]
			+ gx * fy * image_mem[{bx, 9'(by + 1)}]
			+ fx * gy * image_mem[{9'(bx + 1), by}]
			+ fx * fy * image_mem[{9'(bx + 1), 9'(by + 1)}];
		return colors[sum[23:16]];
	endfunction

	// Track configuration and input transfers, compare each output transfer.
	always @(posedge clk or negedge arst_n) begin
		logic [23:0] want;
		if (!arst_n) begin
			x_ratio = RATIO_RESET;
			y_ratio = RATIO_RESET;
			pixel_queue.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pixel_queue.size() == 0) begin
					$display("%0t: unexpected pixel, expected none, actual %h", $time, m_tdata);
					errors++;
				end else begin
					want = pixel_queue.pop_front();
					if (m_tdata[7:0] !== want[7:0]) begin
						$display("%0t: byte0 expected %h actual %h", $time, want[7:0], m_tdata[7:0]);
						errors++;
					end
					if (m_tdata[15:8] !== want[15:8]) begin
						$display("%0t: byte1 expected %h actual %h", $time, want[15:8],
							m_tdata[15:8]);
						errors++;
					end
					if (m_tdata[23:16] !== want[23:16]) begin
						$display("%0t: byte2 expected %h actual %h", $time, want[23:16],
							m_tdata[23:16]);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_WIDTH_RATIO)
					x_ratio = cfg_data;
				else
					y_ratio = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					CMD_SAMPLE: image_mem[{s_tdata[8:0], s_tdata[17:9]}] = s_tdata[25:18];
					CMD_PALETTE: colors[s_tdata[33:26]] = s_tdata[57:34];
					CMD_RENDER: pixel_queue.push_back(shade(s_tdata[69:58], s_tdata[81:70]));
					default: ;
				endcase
			end
			pending = pixel_queue.size();
		end
	end
endmodule

>>> test/bilinear_scaler_palette_test.sv
// Stimulus and verdict for the bilinear scaler with palette.
`timescale 1ns / 100ps

module bilinear_scaler_palette_test;
	import bsp_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 170;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;
	logic [1:0]  s_tuser = CMD_SAMPLE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = REG_WIDTH_RATIO;
	logic [27:0] cfg_data = '0;
	int          pending, errors, cycles;
	int          send_idle_pct, recv_stall_pct;
	logic [27:0] x_ratio, y_ratio;
	bit          written [0:SRC_SIZE*SRC_SIZE-1];

	bilinear_scaler_palette dut (.*);

	bilinear_scaler_palette_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver stalls at random.
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Drive one input transfer; unused fields carry random bits.
	task automatic send(input logic [1:0] cmd, input logic [8:0] a, input logic [8:0] b,
			input logic [7:0] smp, input logic [7:0] pidx, input logic [23:0] col,
			input logic [11:0] dx, input logic [11:0] dy);
		int gap;
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(3, 1) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {6'd0, dy, dx, col, pidx, smp, b, a};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (cmd == CMD_SAMPLE)
			written[{a, b}] = 1'b1;
	endtask

	function automatic logic [8:0] base_of(input logic [11:0] d, input logic [27:0] r);
		logic [47:0] u;
		u = (48'(d) * 2 + 1) * 48'(r) + 48'd65536;
		return ((u >> 17) > 48'(SRC_SIZE - 2)) ? 9'(SRC_SIZE - 2) : u[25:17];
	endfunction

	task automatic put_sample(input logic [8:0] a, input logic [8:0] b, input logic [7:0] v);
		send(CMD_SAMPLE, a, b, v, $urandom, $urandom, $urandom, $urandom);
	endtask

	// A render first writes any of its four neighbors not yet written.
	task automatic render(input logic [11:0] dx, input logic [11:0] dy);
		logic [8:0] bx, by;
		bx = base_of(dx, x_ratio);
		by = base_of(dy, y_ratio);
		for (int i = 0; i < 2; i++)
			for (int j = 0; j < 2; j++)
				if (!written[{9'(bx + i), 9'(by + j)}])
					put_sample(9'(bx + i), 9'(by + j), 8'($urandom));
		send(CMD_RENDER, $urandom, $urandom, $urandom, $urandom, $urandom, dx, dy);
	endtask

	task automatic write_reg(input logic idx, input logic [27:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_WIDTH_RATIO)
			x_ratio = val;
		else
			y_ratio = val;
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		logic [27:0] xs [6], ys [6];
		int pick;
		x_ratio = RATIO_RESET;
		y_ratio = RATIO_RESET;
		send_idle_pct = 6;
		recv_stall_pct = 79;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Every palette entry gets a color before any render.
		for (int i = 0; i < PAL_DEPTH; i++)
			send(CMD_PALETTE, $urandom, $urandom, $urandom, i, $urandom, $urandom, $urandom);

		// Directed: field extremes, unused command, destination extremes.
		send(CMD_PALETTE, $urandom, $urandom, $urandom, 8'd0, 24'h000000, $urandom, $urandom);
		send(CMD_PALETTE, $urandom, $urandom, $urandom, 8'hff, 24'hffffff, $urandom, $urandom);
		put_sample(9'd0, 9'd0, 8'd0);
		put_sample(9'd511, 9'd511, 8'hff);
		put_sample(9'd0, 9'd1, 8'hff);
		put_sample(9'd1, 9'd0, 8'hff);
		put_sample(9'd1, 9'd1, 8'hff);
		send(CMD_NOP, '1, '1, '1, '1, '1, '1, '1);
		render(12'd0, 12'd0);
		render(12'd4095, 12'd4095);
		render(12'd0, 12'd4095);
		render(12'd4095, 12'd0);
		drain();

		xs = '{28'd65536, 28'd1, 28'd134217728, 28'd0, 28'hfffffff, 28'd0};
		ys = '{28'd65536, 28'd134217728, 28'd1, 28'hfffffff, 28'd0, 28'd0};
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				send_idle_pct = 79;
				recv_stall_pct = 6;
			end else if (ph == 4) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			// Later phases use random ratios from 1 to 300000 to spread positions.
			if (ph >= 4) begin
				xs[ph] = $urandom_range(300000, 1);
				ys[ph] = $urandom_range(300000, 1);
			end
			write_reg(REG_WIDTH_RATIO, xs[ph]);
			write_reg(REG_HEIGHT_RATIO, ys[ph]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 1 && n == PHASE_ITEMS / 2)
					drain();
				pick = $urandom_range(99);
				if (pick < 15)
					put_sample($urandom, $urandom, $urandom);
				else if (pick < 20)
					send(CMD_PALETTE, $urandom, $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom);
				else if (pick < 24)
					send(CMD_NOP, $urandom, $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom);
				else if (pick < 60)
					render($urandom_range(300), $urandom_range(300));
				else
					render($urandom, $urandom);
			end
			drain();
		end

		repeat (20) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
